[src/bis_pkg.sv]
package bis_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int PIX_W      = 8;
    localparam int SW_W       = 10;
    localparam int SH_W       = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int FRAC_BITS  = 12;
    localparam int OUT_SHIFT  = 24;

    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

    localparam int QUO_W = SW_W + FRAC_BITS;
    localparam int REM_W = SW_W;
    localparam int CNT_W = $clog2(QUO_W);
    localparam int SX_W  = COL_W + QUO_W;
    localparam int SY_W  = ROW_W + QUO_W;
    localparam int W_W   = FRAC_BITS + 1;
    localparam int TOP_W = PIX_W + W_W;
    localparam int SUM_W = TOP_W + W_W;

    localparam logic [SW_W-1:0] SRC_WIDTH_RST  = SW_W'(320);
    localparam logic [SH_W-1:0] SRC_HEIGHT_RST = SH_W'(240);
    localparam logic [SW_W-1:0] DST_WIDTH_RST  = SW_W'(272);
    localparam logic [SH_W-1:0] DST_HEIGHT_RST = SH_W'(204);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_XLOAD,
        ST_XDIV,
        ST_YLOAD,
        ST_YDIV,
        ST_IDLE,
        ST_A0,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_M1,
        ST_M2
    } t_state;

    function automatic logic [FRAME_AW-1:0] frame_addr(
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] row
    );
        return FRAME_AW'(FRAME_AW'(row) * FRAME_AW'(MAX_WIDTH) + FRAME_AW'(col));
    endfunction

endpackage

[src/bis_ram.sv]
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/bilinear_image_scaler_top.sv]
// Bilinear scaler over one stored 8-bit source frame. A write transaction
// stores a pixel and busy stays low. For a read transaction of an in-range
// destination pixel the single-ported frame memory is read four times, one
// neighbor per cycle, then two blend steps follow, with busy high until the
// result is ready. An out-of-range read is answered in the cycle after accept.
// The result strobe o_result_valid is high for one cycle and cannot be held
// off. After reset and after every configuration write the two step ratios
// are recomputed by a bit-serial divider with busy high;
// configuration writes are always taken.
module bilinear_image_scaler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_req_type,
    input  logic [bis_pkg::COL_W-1:0]      i_col,
    input  logic [bis_pkg::ROW_W-1:0]      i_row,
    input  logic [bis_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                           o_result_valid,
    output logic [bis_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                           o_out_of_range,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import bis_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [SW_W-1:0] r_src_width;
    logic [SH_W-1:0] r_src_height;
    logic [SW_W-1:0] r_dst_width;
    logic [SH_W-1:0] r_dst_height;

    logic [QUO_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div_cnt;
    logic [QUO_W-1:0] r_xr;
    logic [QUO_W-1:0] r_yr;

    logic [SX_W-1:0]  r_sx;
    logic [SY_W-1:0]  r_sy;
    logic [COL_W-1:0] r_x1;
    logic [COL_W-1:0] r_x2;
    logic [ROW_W-1:0] r_y1;
    logic [ROW_W-1:0] r_y2;
    logic [PIX_W-1:0] r_p11;
    logic [PIX_W-1:0] r_p12;
    logic [TOP_W-1:0] r_top;
    logic [TOP_W-1:0] r_bot;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_pixel_out;
    logic             r_oor;

    logic [SW_W-1:0] w_sw;
    logic [SH_W-1:0] w_sh;
    logic [SW_W-1:0] w_dw;
    logic [SH_W-1:0] w_dh;
    logic [SW_W-1:0] w_sw_m1;
    logic [SH_W-1:0] w_sh_m1;

    logic             w_cfg_we;
    logic             w_accept;
    logic             w_rd_oor;
    logic             w_wr_in;

    logic [REM_W-1:0] w_divisor;
    logic [REM_W:0]   w_trial;
    logic             w_ge;
    logic [REM_W-1:0] w_rem_n;
    logic             w_div_last;

    logic [SX_W-FRAC_BITS-1:0] w_x1_raw;
    logic [SY_W-FRAC_BITS-1:0] w_y1_raw;
    logic [COL_W-1:0]          w_x1;
    logic [COL_W-1:0]          w_x2;
    logic [ROW_W-1:0]          w_y1;
    logic [ROW_W-1:0]          w_y2;

    logic [W_W-1:0]   w_fx;
    logic [W_W-1:0]   w_gx;
    logic [W_W-1:0]   w_fy;
    logic [W_W-1:0]   w_gy;
    logic [TOP_W-1:0] w_blend_row;
    logic [SUM_W-1:0] w_sum;

    logic                w_mem_we;
    logic [FRAME_AW-1:0] w_mem_addr;
    logic [PIX_W-1:0]    w_mem_rdata;

    assign w_sw = (r_src_width == '0) ? SW_W'(1) :
                  (r_src_width > SW_W'(MAX_WIDTH)) ? SW_W'(MAX_WIDTH) : r_src_width;
    assign w_sh = (r_src_height == '0) ? SH_W'(1) :
                  (r_src_height > SH_W'(MAX_HEIGHT)) ? SH_W'(MAX_HEIGHT) : r_src_height;
    assign w_dw = (r_dst_width == '0) ? SW_W'(1) : r_dst_width;
    assign w_dh = (r_dst_height == '0) ? SH_W'(1) : r_dst_height;
    assign w_sw_m1 = w_sw - SW_W'(1);
    assign w_sh_m1 = w_sh - SH_W'(1);

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_accept    = start && !busy;
    assign w_rd_oor    = ({1'b0, i_col} >= w_dw) || ({1'b0, i_row} >= w_dh);
    assign w_wr_in     = ({1'b0, i_col} < w_sw) && ({1'b0, i_row} < w_sh);

    // bit-serial restoring divider
    assign w_divisor  = (r_state == ST_YDIV) ? REM_W'(w_dh) : REM_W'(w_dw);
    assign w_trial    = {r_rem, r_quo[QUO_W-1]};
    assign w_ge       = w_trial >= {1'b0, w_divisor};
    assign w_rem_n    = w_ge ? REM_W'(w_trial - {1'b0, w_divisor}) : w_trial[REM_W-1:0];
    assign w_div_last = r_div_cnt == CNT_W'(QUO_W - 1);

    // neighbor coordinates, second one clamped to the last row or column
    assign w_x1_raw = r_sx[SX_W-1:FRAC_BITS];
    assign w_y1_raw = r_sy[SY_W-1:FRAC_BITS];
    assign w_x1 = (w_x1_raw > (SX_W-FRAC_BITS)'(w_sw_m1)) ? w_sw_m1[COL_W-1:0]
                                                          : w_x1_raw[COL_W-1:0];
    assign w_y1 = (w_y1_raw > (SY_W-FRAC_BITS)'(w_sh_m1)) ? w_sh_m1[ROW_W-1:0]
                                                          : w_y1_raw[ROW_W-1:0];
    assign w_x2 = (SW_W'(w_x1) == w_sw_m1) ? w_x1 : w_x1 + COL_W'(1);
    assign w_y2 = (SH_W'(w_y1) == w_sh_m1) ? w_y1 : w_y1 + ROW_W'(1);

    assign w_fx = W_W'(r_sx[FRAC_BITS-1:0]);
    assign w_fy = W_W'(r_sy[FRAC_BITS-1:0]);
    assign w_gx = W_W'(1 << FRAC_BITS) - w_fx;
    assign w_gy = W_W'(1 << FRAC_BITS) - w_fy;

    always_comb begin
        logic [PIX_W-1:0] v_left;
        v_left = (r_state == ST_M1) ? r_p12 : r_p11;
        w_blend_row = TOP_W'(w_gx) * TOP_W'(v_left) + TOP_W'(w_fx) * TOP_W'(w_mem_rdata);
    end

    assign w_sum = SUM_W'(w_gy) * SUM_W'(r_top) + SUM_W'(w_fy) * SUM_W'(r_bot);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_XLOAD: n_state = ST_XDIV;
            ST_XDIV:  n_state = w_div_last ? ST_YLOAD : ST_XDIV;
            ST_YLOAD: n_state = ST_YDIV;
            ST_YDIV:  n_state = w_div_last ? ST_IDLE : ST_YDIV;
            ST_IDLE: begin
                if (start && i_req_type == REQ_READ && !w_rd_oor) begin
                    n_state = ST_A0;
                end
            end
            ST_A0:    n_state = ST_A1;
            ST_A1:    n_state = ST_A2;
            ST_A2:    n_state = ST_A3;
            ST_A3:    n_state = ST_M1;
            ST_M1:    n_state = ST_M2;
            ST_M2:    n_state = ST_IDLE;
            default:  n_state = ST_XLOAD;
        endcase
        if (w_cfg_we) begin
            n_state = ST_XLOAD;
        end
    end

    always_comb begin
        busy       = 1'b1;
        w_mem_we   = 1'b0;
        w_mem_addr = frame_addr(w_x1, w_y1);
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                w_mem_we   = start && i_req_type == REQ_WRITE && w_wr_in;
                w_mem_addr = frame_addr(i_col, i_row);
            end
            ST_A0:   w_mem_addr = frame_addr(w_x1, w_y1);
            ST_A1:   w_mem_addr = frame_addr(r_x2, r_y1);
            ST_A2:   w_mem_addr = frame_addr(r_x1, r_y2);
            ST_A3:   w_mem_addr = frame_addr(r_x2, r_y2);
            default: w_mem_addr = frame_addr(w_x1, w_y1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_XLOAD;
            r_src_width  <= SRC_WIDTH_RST;
            r_src_height <= SRC_HEIGHT_RST;
            r_dst_width  <= DST_WIDTH_RST;
            r_dst_height <= DST_HEIGHT_RST;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            if (w_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SW_W-1:0];
                    CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SH_W-1:0];
                    CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[SW_W-1:0];
                    CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[SH_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_XLOAD || r_state == ST_YLOAD) begin
                r_div_cnt <= '0;
            end else if (r_state == ST_XDIV || r_state == ST_YDIV) begin
                r_div_cnt <= r_div_cnt + CNT_W'(1);
            end
            if (r_state == ST_M2) begin
                r_out_valid <= 1'b1;
            end else if (w_accept && i_req_type == REQ_READ && w_rd_oor) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_XLOAD: begin
                r_quo <= {w_sw, FRAC_BITS'(0)};
                r_rem <= '0;
            end
            ST_YLOAD: begin
                r_quo <= QUO_W'({w_sh, FRAC_BITS'(0)});
                r_rem <= '0;
            end
            ST_XDIV, ST_YDIV: begin
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_rem <= w_rem_n;
                if (w_div_last && r_state == ST_XDIV) begin
                    r_xr <= {r_quo[QUO_W-2:0], w_ge};
                end
                if (w_div_last && r_state == ST_YDIV) begin
                    r_yr <= {r_quo[QUO_W-2:0], w_ge};
                end
            end
            ST_IDLE: begin
                if (start) begin
                    r_sx        <= SX_W'(i_col) * SX_W'(r_xr);
                    r_sy        <= SY_W'(i_row) * SY_W'(r_yr);
                    r_pixel_out <= '0;
                    r_oor       <= 1'b1;
                end
            end
            ST_A0: begin
                r_x1 <= w_x1;
                r_x2 <= w_x2;
                r_y1 <= w_y1;
                r_y2 <= w_y2;
            end
            ST_A1: r_p11 <= w_mem_rdata;
            ST_A2: r_top <= w_blend_row;
            ST_A3: r_p12 <= w_mem_rdata;
            ST_M1: r_bot <= w_blend_row;
            ST_M2: begin
                r_pixel_out <= w_sum[OUT_SHIFT +: PIX_W];
                r_oor       <= 1'b0;
            end
            default: ;
        endcase
    end

    bis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (i_pixel_in),
        .o_rdata (w_mem_rdata)
    );

    assign o_result_valid = r_out_valid;
    assign o_pixel_out    = r_pixel_out;
    assign o_out_of_range = r_oor;

`ifndef SYNTHESIS
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> r_state == ST_IDLE)
        else $error("frame write outside idle");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_out_of_range |-> o_pixel_out == '0)
        else $error("out-of-range result carries nonzero pixel");

    a_blend_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_M2 |=> o_result_valid && !o_out_of_range)
        else $error("blend finished without an in-range result");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_READ && !w_rd_oor && !w_cfg_we
        |=> busy && !o_result_valid)
        else $error("in-range read did not start the fetch sequence");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_we |=> r_state == ST_XLOAD)
        else $error("configuration write did not restart the ratio division");
`endif

endmodule

[tb/sv/tb_bilinear_image_scaler_top.sv]
`timescale 1ns / 1ps

module tb_bilinear_image_scaler_top;
    import bis_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;
    localparam int unsigned DST_COLS_MAX = (1 << SW_W) - 1;
    localparam int unsigned DST_ROWS_MAX = (1 << SH_W) - 1;
    localparam int unsigned ONE_Q12      = 1 << FRAC_BITS;

    typedef struct {
        logic             req;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pix;
        bit               drain;
    } pixel_req_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             oor;
    } scaled_pix_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic                  i_req_type     = REQ_WRITE;
    logic [COL_W-1:0]      i_col          = '0;
    logic [ROW_W-1:0]      i_row          = '0;
    logic [PIX_W-1:0]      i_pixel_in     = '0;
    logic                  o_result_valid;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_out_of_range;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    pixel_req_t  pending_q[$];
    scaled_pix_t expected_q[$];
    pixel_req_t  cur_req;

    logic [PIX_W-1:0] frame_mem [FRAME_DEPTH];
    bit               src_written [FRAME_DEPTH];

    int unsigned sw_reg = 320;
    int unsigned sh_reg = 240;
    int unsigned dw_reg = 272;
    int unsigned dh_reg = 204;

    int err_count  = 0;
    int issued     = 0;
    int burst_left = 8;
    int gap_left   = 0;

    bilinear_image_scaler_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_pixel_in     (i_pixel_in),
        .o_result_valid (o_result_valid),
        .o_pixel_out    (o_pixel_out),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned src_cols();
        return dim(sw_reg, MAX_WIDTH);
    endfunction

    function automatic int unsigned src_rows();
        return dim(sh_reg, MAX_HEIGHT);
    endfunction

    function automatic int unsigned dst_cols();
        return dim(dw_reg, DST_COLS_MAX);
    endfunction

    function automatic int unsigned dst_rows();
        return dim(dh_reg, DST_ROWS_MAX);
    endfunction

    function automatic int unsigned pix_index(input int unsigned c, input int unsigned r);
        return r * MAX_WIDTH + c;
    endfunction

    // map a destination coordinate onto two source neighbors and a Q12 fraction
    function automatic void map_axis(
        input  int unsigned pos,
        input  int unsigned src_n,
        input  int unsigned dst_n,
        output int unsigned lo,
        output int unsigned hi,
        output int unsigned frac
    );
        int unsigned ratio;
        int unsigned p;
        ratio = (src_n << FRAC_BITS) / dst_n;
        p     = pos * ratio;
        lo    = p >> FRAC_BITS;
        if (lo > src_n - 1) lo = src_n - 1;
        hi    = (lo == src_n - 1) ? lo : lo + 1;
        frac  = (p - (lo << FRAC_BITS)) & (ONE_Q12 - 1);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    task automatic apply_request(input pixel_req_t t);
        int unsigned     x1, x2, y1, y2, fx, fy, gx, gy;
        longint unsigned top, bot, acc;
        scaled_pix_t     res;
        if (t.req == REQ_WRITE) begin
            if (t.col < src_cols() && t.row < src_rows())
                frame_mem[pix_index(t.col, t.row)] = t.pix;
        end else begin
            res.pix = '0;
            res.oor = 1'b1;
            if (t.col < dst_cols() && t.row < dst_rows()) begin
                map_axis(t.col, src_cols(), dst_cols(), x1, x2, fx);
                map_axis(t.row, src_rows(), dst_rows(), y1, y2, fy);
                gx  = ONE_Q12 - fx;
                gy  = ONE_Q12 - fy;
                top = 64'(gx) * frame_mem[pix_index(x1, y1)]
                    + 64'(fx) * frame_mem[pix_index(x2, y1)];
                bot = 64'(gx) * frame_mem[pix_index(x1, y2)]
                    + 64'(fx) * frame_mem[pix_index(x2, y2)];
                acc = 64'(gy) * top + 64'(fy) * bot;
                res.pix = PIX_W'(acc >> OUT_SHIFT);
                res.oor = 1'b0;
            end
            expected_q.push_back(res);
        end
    endtask

    task automatic push_write(
        input int unsigned c,
        input int unsigned r,
        input logic [PIX_W-1:0] p
    );
        pixel_req_t t;
        t.req   = REQ_WRITE;
        t.col   = COL_W'(c);
        t.row   = ROW_W'(r);
        t.pix   = p;
        t.drain = 1'b0;
        if (c < src_cols() && r < src_rows()) src_written[pix_index(c, r)] = 1'b1;
        pending_q.push_back(t);
        issued++;
    endtask

    task automatic fill_src(input int unsigned c, input int unsigned r);
        if (!src_written[pix_index(c, r)]) push_write(c, r, PIX_W'($urandom));
    endtask

    task automatic push_read(
        input int unsigned c,
        input int unsigned r,
        input bit drain = 1'b0
    );
        pixel_req_t  t;
        int unsigned x1, x2, y1, y2, fx, fy;
        if (c < dst_cols() && r < dst_rows()) begin
            map_axis(c, src_cols(), dst_cols(), x1, x2, fx);
            map_axis(r, src_rows(), dst_rows(), y1, y2, fy);
            fill_src(x1, y1);
            fill_src(x2, y1);
            fill_src(x1, y2);
            fill_src(x2, y2);
        end
        t.req   = REQ_READ;
        t.col   = COL_W'(c);
        t.row   = ROW_W'(r);
        t.pix   = PIX_W'($urandom);
        t.drain = drain;
        pending_q.push_back(t);
        issued++;
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || start || expected_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_quiet();
        repeat (8) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  sw_reg = val;
            CFG_SRC_HEIGHT: sh_reg = val[SH_W-1:0];
            CFG_DST_WIDTH:  dw_reg = val;
            CFG_DST_HEIGHT: dh_reg = val[SH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(
        input logic [CFG_DATA_W-1:0] sw,
        input logic [CFG_DATA_W-1:0] sh,
        input logic [CFG_DATA_W-1:0] dw,
        input logic [CFG_DATA_W-1:0] dh
    );
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
    endtask

    task automatic random_traffic(input int n);
        int          stop_at;
        int          sel;
        int unsigned c, r, cmax, rmax;
        stop_at = issued + n;
        push_read(0, 0, 1'b1);
        while (issued < stop_at) begin
            sel  = $urandom_range(0, 99);
            cmax = (dst_cols() > MAX_WIDTH) ? MAX_WIDTH : dst_cols();
            rmax = (dst_rows() > MAX_HEIGHT) ? MAX_HEIGHT : dst_rows();
            if (sel < 55) begin
                push_read($urandom_range(0, cmax - 1), $urandom_range(0, rmax - 1),
                          $urandom_range(0, 49) == 0);
            end else if (sel < 65) begin
                c = $urandom_range(0, MAX_WIDTH - 1);
                r = $urandom_range(0, MAX_HEIGHT - 1);
                if (dst_cols() < MAX_WIDTH && $urandom_range(0, 1))
                    c = $urandom_range(dst_cols(), MAX_WIDTH - 1);
                else if (dst_rows() < MAX_HEIGHT)
                    r = $urandom_range(dst_rows(), MAX_HEIGHT - 1);
                push_read(c, r);
            end else if (sel < 75) begin
                push_read($urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1));
            end else if (sel < 90) begin
                push_write($urandom_range(0, src_cols() - 1), $urandom_range(0, src_rows() - 1),
                           PIX_W'($urandom));
            end else begin
                push_write($urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1),
                           PIX_W'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        bit free;
        free = !start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_request(cur_req);
                free = 1'b1;
            end
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].drain && expected_q.size() != 0)) begin
                    cur_req = pending_q.pop_front();
                    start      <= 1'b1;
                    i_req_type <= cur_req.req;
                    i_col      <= cur_req.col;
                    i_row      <= cur_req.row;
                    i_pixel_in <= cur_req.pix;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        scaled_pix_t want;
        if (i_rst_n && o_result_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction pixel=%0d oor=%0b",
                                          o_pixel_out, o_out_of_range));
            end else begin
                want = expected_q.pop_front();
                if (o_pixel_out !== want.pix)
                    report_mismatch($sformatf("pixel_out got %0d want %0d",
                                              o_pixel_out, want.pix));
                if (o_out_of_range !== want.oor)
                    report_mismatch($sformatf("out_of_range got %0b want %0b",
                                              o_out_of_range, want.oor));
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_write(0, 0, 8'd255);
        push_write(1, 0, 8'd255);
        push_write(0, 1, 8'd255);
        push_write(1, 1, 8'd255);
        push_read(0, 0);
        push_write(511, 255, 8'hAA);
        push_write(320, 0, 8'h55);
        push_write(0, 240, 8'h0F);
        push_write(319, 239, 8'd0);
        push_read(271, 203);
        push_read(272, 0);
        push_read(0, 204);
        push_read(511, 255, 1'b1);
        push_read(136, 102);
        push_read(255, 128);

        random_traffic(110);

        write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        set_sizes(1, 1, 1, 1);
        random_traffic(100);
        set_sizes(512, 256, 512, 256);
        random_traffic(110);
        set_sizes(0, 0, 0, 0);
        random_traffic(80);
        set_sizes(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        random_traffic(110);
        set_sizes(8, 4, 16, 8);
        random_traffic(100);
        set_sizes(512, 256, 64, 32);
        random_traffic(100);
        set_sizes(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        random_traffic(100);
        set_sizes($urandom_range(1, 512), $urandom_range(1, 256),
                  $urandom_range(1, 512), $urandom_range(1, 256));
        random_traffic(110);

        wait_quiet();
        repeat (20) @(negedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d transactions never returned", expected_q.size()));
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
